// ===== hdl/packet_mode_depacketizer_macros.svh =====
// Assertion macros shared by the depacketizer RTL.
`ifndef PACKET_MODE_DEPACKETIZER_MACROS_SVH
`define PACKET_MODE_DEPACKETIZER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PMD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pmd_pkg.sv =====
// ----------------------------------------------------------------------------
// Packet-mode depacketizer package
// Shared constants, item types and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package pmd_pkg;

  localparam int NUM_PACKET_IDS = 4;
  localparam int ID_W           = 2;
  localparam int CI_W           = 3;
  localparam int POS_W          = 9;
  localparam int BYTE_W         = 8;
  localparam int CRC_W          = 16;
  localparam int IN_DATA_W      = 8;
  localparam int OUT_DATA_W     = 24;
  localparam int CFG_DATA_W     = 8;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

  // Configuration register indexes
  localparam logic CFG_ENABLE     = 1'b0;
  localparam logic CFG_PACKET_LEN = 1'b1;

  // Result kinds
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              frame_start;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] payload_byte;
    logic              useful;
    logic [ID_W-1:0]   packet_id;
    logic              crc_ok;
    logic              unit_start;
    logic              unit_complete;
    logic              unit_broken;
    logic              length_error;
    logic              continuity_error;
  } result_t;

  // CRC-16, polynomial 0x1021, one byte MSB first.
  function automatic logic [CRC_W-1:0] pmd_crc8(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    logic             fb;
    c = crc_in;
    for (int i = 0; i < BYTE_W; i++) begin
      fb = c[CRC_W-1] ^ b[BYTE_W-1-i];
      c  = {c[CRC_W-2:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/pmd_in_stage.sv =====
// ----------------------------------------------------------------------------
// Depacketizer input stage
// Registers one input transfer and holds it until the core takes it.
// ----------------------------------------------------------------------------
module pmd_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  pmd_pkg::item_t in_item,
  input  logic          take,
  output logic          held_valid,
  output pmd_pkg::item_t held_item
);
  import pmd_pkg::*;

  logic load;
  logic held_valid_next;

  assign in_ready = !held_valid || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    if (load) begin
      held_valid_next = 1'b1;
    end else if (take) begin
      held_valid_next = 1'b0;
    end else begin
      held_valid_next = held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_item <= in_item;
    end
  end

endmodule

// ===== hdl/pmd_core.sv =====
// ----------------------------------------------------------------------------
// Depacketizer core
// Packet position, CRC check, continuity and unit-ok tracking per packet id.
// ----------------------------------------------------------------------------
module pmd_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [pmd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                       fire,
  input  pmd_pkg::item_t             item,
  output logic                       res_valid,
  output pmd_pkg::result_t           res
);
  import pmd_pkg::*;

  logic                enable;
  logic [BYTE_W-1:0]   packet_len;
  logic [POS_W-1:0]    byte_position, byte_position_next;
  logic [CRC_W-1:0]    crc_register, crc_register_next;
  logic [BYTE_W-1:0]   header_latch, header_latch_next;
  logic [BYTE_W-1:0]   useful_length, useful_length_next;
  logic [BYTE_W-1:0]   received_crc_high, received_crc_high_next;
  logic [CI_W-1:0]     continuity_store [NUM_PACKET_IDS];
  logic [CI_W-1:0]     continuity_store_next [NUM_PACKET_IDS];
  logic [NUM_PACKET_IDS-1:0] unit_ok_flags, unit_ok_flags_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      packet_len <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE:     enable     <= cfg_data[0];
        CFG_PACKET_LEN: packet_len <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] plen9;
    logic [CRC_W-1:0] crc_cur;
    logic [CRC_W-1:0] crc_adv;
    logic [ID_W-1:0]  id;
    logic             ppi;
    logic             first;
    logic             last;
    logic [CI_W-1:0]  ci;
    logic             len_bad;
    logic             ok;
    logic             cont_err;
    logic             len_err;
    logic             complete;
    logic             flag;

    byte_position_next     = byte_position;
    crc_register_next      = crc_register;
    header_latch_next      = header_latch;
    useful_length_next     = useful_length;
    received_crc_high_next = received_crc_high;
    continuity_store_next  = continuity_store;
    unit_ok_flags_next     = unit_ok_flags;
    res_valid              = 1'b0;
    res                    = '0;

    pos      = item.frame_start ? '0 : byte_position;
    crc_cur  = item.frame_start ? CRC_INIT : crc_register;
    crc_adv  = pmd_crc8(crc_cur, item.data_byte);
    plen9    = {1'b0, packet_len};
    id       = header_latch[5:4];
    ppi      = header_latch[3];
    first    = header_latch[7];
    last     = header_latch[6];
    ci       = header_latch[CI_W-1:0];
    len_bad  = (packet_len != '0) && (useful_length >= packet_len);
    ok       = ({received_crc_high, item.data_byte} == ~crc_cur);
    cont_err = ((continuity_store[id] + CI_W'(1)) != ci);
    len_err  = ppi && len_bad;
    flag     = unit_ok_flags[id];
    complete = 1'b0;

    if (fire && enable) begin
      byte_position_next = pos;
      crc_register_next  = crc_cur;
      if (pos == '0) begin
        header_latch_next  = item.data_byte;
        useful_length_next = '0;
        crc_register_next  = crc_adv;
        byte_position_next = POS_W'(1);
      end else if (pos <= plen9) begin
        crc_register_next  = crc_adv;
        byte_position_next = pos + POS_W'(1);
        res_valid          = 1'b1;
        res.kind           = KIND_DATA;
        res.payload_byte   = item.data_byte;
        res.packet_id      = id;
        if (ppi && pos == POS_W'(1)) begin
          useful_length_next = item.data_byte;
          res.useful         = 1'b0;
        end else if (ppi) begin
          res.useful = !len_bad && ((pos - POS_W'(2)) < {1'b0, useful_length});
        end else begin
          res.useful = 1'b1;
        end
      end else if (pos == plen9 + POS_W'(1)) begin
        received_crc_high_next = item.data_byte;
        byte_position_next     = pos + POS_W'(1);
      end else begin
        // last CRC byte: verdict, then realign for the next header
        res_valid          = 1'b1;
        res.kind           = KIND_VERDICT;
        res.packet_id      = id;
        res.crc_ok         = ok;
        byte_position_next = '0;
        crc_register_next  = CRC_INIT;
        if (ok) begin
          if (cont_err) begin
            flag = 1'b0;
          end
          if (first) begin
            flag = 1'b1;
          end
          complete = last && flag;
          if (len_err) begin
            flag     = 1'b0;
            complete = 1'b0;
          end
          if (ppi && first && last && !len_err && useful_length == '0) begin
            complete = 1'b0;
          end
          res.unit_start       = first;
          res.unit_complete    = complete;
          res.unit_broken      = !flag;
          res.length_error     = len_err;
          res.continuity_error = cont_err;
          // delivered unit starts over
          if (complete) begin
            flag = 1'b0;
          end
          unit_ok_flags_next[id]    = flag;
          continuity_store_next[id] = ci;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      crc_register      <= CRC_INIT;
      header_latch      <= '0;
      useful_length     <= '0;
      received_crc_high <= '0;
      unit_ok_flags     <= '0;
      for (int i = 0; i < NUM_PACKET_IDS; i++) begin
        continuity_store[i] <= '0;
      end
    end else begin
      byte_position     <= byte_position_next;
      crc_register      <= crc_register_next;
      header_latch      <= header_latch_next;
      useful_length     <= useful_length_next;
      received_crc_high <= received_crc_high_next;
      unit_ok_flags     <= unit_ok_flags_next;
      continuity_store  <= continuity_store_next;
    end
  end

endmodule

// ===== hdl/pmd_out_stage.sv =====
// ----------------------------------------------------------------------------
// Depacketizer output stage
// Result register that holds a result until the downstream transfer.
// ----------------------------------------------------------------------------
module pmd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  pmd_pkg::result_t res_in,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output pmd_pkg::result_t res_out
);
  import pmd_pkg::*;

  logic out_valid_next;

  assign space = !out_valid || out_ready;

  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ===== hdl/packet_mode_depacketizer.sv =====
// A byte sits in the input register; the result register loads its result at the edge on
// which the core takes the byte, and the core waits while the output register is full.
// Throughput: one byte per cycle unless the output stalls; the core's state update sets it.
// Reset (rst, synchronous, active high): both stages empty, decoding disabled,
// packet length zero, CRC all ones, continuity and unit-ok flags cleared.
// ----------------------------------------------------------------------------
// Packet-mode depacketizer
// Byte stream in, tentative data bytes and CRC-checked packet verdicts out.
// ----------------------------------------------------------------------------
`include "packet_mode_depacketizer_macros.svh"

module packet_mode_depacketizer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [pmd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [pmd_pkg::IN_DATA_W-1:0]    s_tdata,   // [7:0] data_byte
  input  logic                             s_tuser,   // [0] frame_start
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pmd_pkg::OUT_DATA_W-1:0]   m_tdata,   // [7:0] payload_byte, [8] useful,
                                                      // [10:9] packet_id, [11] crc_ok,
                                                      // [12] unit_start, [13] unit_complete,
                                                      // [14] unit_broken, [15] length_error,
                                                      // [16] continuity_error, [23:17] zero
  output logic                             m_tuser    // [0] kind
);
  import pmd_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    fire;
  logic    space;
  logic    res_valid;
  result_t res;
  result_t res_out;

  assign in_item.data_byte   = s_tdata;
  assign in_item.frame_start = s_tuser;
  assign fire = held_valid && space;

  pmd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .take       (fire),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  pmd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (held_item),
    .res_valid (res_valid),
    .res       (res)
  );

  pmd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && res_valid),
    .res_in    (res),
    .space     (space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res_out   (res_out)
  );

  assign m_tuser = res_out.kind;
  assign m_tdata = {7'b0, res_out.continuity_error, res_out.length_error,
                    res_out.unit_broken, res_out.unit_complete, res_out.unit_start,
                    res_out.crc_ok, res_out.packet_id, res_out.useful,
                    res_out.payload_byte};

  `PMD_ASSERT_NOW(a_stall_blocks_input, held_valid && m_tvalid && !m_tready, !s_tready, "input accepted while both stages are full")
  `PMD_ASSERT_NOW(a_failed_crc_quiet, m_tvalid && m_tuser == KIND_VERDICT && !m_tdata[11], m_tdata[16:12] == 5'b0, "flags set on a verdict with failed CRC")
  `PMD_ASSERT_NOW(a_complete_is_clean, m_tvalid && m_tdata[13], m_tuser == KIND_VERDICT && m_tdata[11] && !m_tdata[15], "unit complete without good CRC or with length error")
  `PMD_ASSERT_NEXT(a_fire_loads_result, fire && res_valid, m_tvalid, "result lost between core and output register")

endmodule
